[design/ffpc_pkg.sv]
// field format pattern check: shared types, character codes and helper functions
// no dependencies
`default_nettype none

package ffpc_pkg;

   localparam int PatMax = 16;

   localparam logic [7:0] CHAR_REPEAT = 8'h24;
   localparam logic [7:0] CHAR_DIGIT  = 8'h23;
   localparam logic [7:0] CHAR_ALPHA  = 8'h58;
   localparam logic [7:0] CHAR_PRINT  = 8'h5A;
   localparam logic [7:0] CHAR_ESCAPE = 8'h5C;

   typedef enum logic [1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // one classified value byte as it travels from front to back
   typedef struct packed {
      logic [7:0] ch;
      logic       is_digit;
      logic       is_alpha;
      logic       is_print;
      logic       drop;
      logic       last;
   } word_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } elem_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic elem_type elem_at(input logic [127:0] pattern,
                                        input logic [4:0]   len_eff,
                                        input logic [5:0]   idx);
      elem_type e;
      e.valid = (idx < {1'b0, len_eff});
      e.ch    = pattern[{idx[3:0], 3'b000} +: 8];
      return e;
   endfunction

   function automatic logic class_ok(input elem_type e, input word_type w);
      logic ok;
      if (!e.valid) begin
         ok = 1'b0;
      end else begin
         case (e.ch)
            CHAR_DIGIT: ok = w.is_digit;
            CHAR_ALPHA: ok = w.is_alpha;
            CHAR_PRINT: ok = w.is_print;
            default:    ok = (w.ch == e.ch);
         endcase
      end
      return ok;
   endfunction

   function automatic logic [4:0] sat_pos(input logic [5:0] p);
      return (p > 6'(PatMax)) ? 5'(PatMax) : p[4:0];
   endfunction

endpackage

`default_nettype wire

[design/ffpc_front.sv]
// front end: classifies each accepted value byte and tracks backslash dropping
// depends on ffpc_pkg
`default_nettype none

module ffpc_front
   import ffpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] value_char,
   input  wire logic       last_char,
   output word_type        word
);

   logic skip_ff;
   logic skip_in;
   logic drop;

   assign drop = skip_ff && (value_char == CHAR_ESCAPE);

   always_comb begin
      word.ch       = value_char;
      word.is_digit = (value_char >= 8'h30) && (value_char <= 8'h39);
      word.is_alpha = ((value_char >= 8'h41) && (value_char <= 8'h5A)) ||
                      ((value_char >= 8'h61) && (value_char <= 8'h7A));
      word.is_print = (value_char >= 8'h20) && (value_char <= 8'h7E);
      word.drop     = drop;
      word.last     = last_char;
   end

   always_comb begin
      skip_in = skip_ff;
      if (accept) begin
         skip_in = last_char ? 1'b1 : !drop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
      end else begin
         skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

[design/ffpc_queue.sv]
// short word queue between front and back ends
// depends on ffpc_pkg
`default_nettype none

module ffpc_queue
   import ffpc_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire word_type   push_word,
   input  wire logic       pop,
   output word_type        head_word,
   output queue_status_type status
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   word_type              data_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CountWidth'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_word    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

[design/ffpc_back.sv]
// back end: walks the format pattern one word per cycle unless a held result
// stalls a last word, and registers the verdict; depends on ffpc_pkg
`default_nettype none

module ffpc_back
   import ffpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [127:0] pattern,
   input  wire logic [4:0]   len_eff,
   input  wire word_type     word,
   input  wire logic         word_valid,
   output logic              pop,
   output logic              rsp_valid,
   output logic              rsp_format_ok,
   input  wire logic         rsp_stall
);

   logic [4:0] pos_ff, pos_in;
   logic       rep_ff, rep_in;
   logic       mis_ff, mis_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff, rsp_ok_in;

   logic [5:0] pos_w;
   logic       consume_en, stay, leave;
   elem_type   e0, e1, e2, e3, eb, eb1, ee;
   logic [4:0] base, pos_c, pe, pf;
   logic       rep_c, mis_c, ok;

   assign pos_w = {1'b0, pos_ff};
   assign e0    = elem_at(pattern, len_eff, pos_w);
   assign e1    = elem_at(pattern, len_eff, pos_w + 6'd1);
   assign e2    = elem_at(pattern, len_eff, pos_w + 6'd2);
   assign e3    = elem_at(pattern, len_eff, pos_w + 6'd3);

   assign consume_en = !word.drop && !mis_ff && (len_eff != 5'd0);
   assign stay       = rep_ff && class_ok(e1, word);
   assign leave      = rep_ff && !stay;
   assign base       = leave ? sat_pos(pos_w + 6'd2) : pos_ff;
   assign eb         = leave ? e2 : e0;
   assign eb1        = leave ? e3 : e1;

   // step through the pattern for one consumed byte
   always_comb begin
      pos_c = pos_ff;
      rep_c = rep_ff;
      mis_c = mis_ff;
      if (consume_en && !stay) begin
         rep_c = 1'b0;
         pos_c = base;
         if (eb.valid && (eb.ch == CHAR_REPEAT)) begin
            if (class_ok(eb1, word)) begin
               rep_c = 1'b1;
            end else begin
               mis_c = 1'b1;
            end
         end else if (class_ok(eb, word)) begin
            pos_c = sat_pos({1'b0, base} + 6'd1);
         end else begin
            mis_c = 1'b1;
         end
      end
   end

   // end of value: close the repeat, pass over one trailing dollar
   assign pe = rep_c ? sat_pos({1'b0, pos_c} + 6'd2) : pos_c;
   assign ee = elem_at(pattern, len_eff, {1'b0, pe});
   assign pf = (ee.valid && (ee.ch == CHAR_REPEAT)) ? sat_pos({1'b0, pe} + 6'd1) : pe;
   assign ok = (len_eff == 5'd0) ? 1'b1 : (mis_c ? 1'b0 : (pf >= len_eff));

   assign pop = word_valid && (!word.last || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      pos_in = pos_ff;
      rep_in = rep_ff;
      mis_in = mis_ff;
      if (pop) begin
         if (word.last) begin
            pos_in = '0;
            rep_in = 1'b0;
            mis_in = 1'b0;
         end else begin
            pos_in = pos_c;
            rep_in = rep_c;
            mis_in = mis_c;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      if (pop && word.last) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rep_ff       <= 1'b0;
         mis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rep_ff       <= rep_in;
         mis_ff       <= mis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_format_ok = rsp_ok_ff;

endmodule

`default_nettype wire

[design/field_format_pattern_check.sv]
// Field format pattern check. Takes one value byte per cycle on the req_ channel, unless
// req_stall holds it, and gives one pass/fail word on rsp_ for each byte marked last. An
// accepted byte is written into a QUEUE_DEPTH-word queue and then taken by the pattern
// walker, which registers the verdict onto rsp_. The walker retires one byte per cycle
// unless a held result stalls a last byte; req_stall rises only when the queue is full,
// which happens only while rsp_stall holds a result. The user must write the pattern
// registers through csr_ only while no value is in flight; the block does not enforce it.
// depends on ffpc_pkg, ffpc_front, ffpc_queue, ffpc_back
`default_nettype none

module field_format_pattern_check
   import ffpc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_value_char,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_format_ok,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic [63:0]      pattern_low_ff;
   logic [63:0]      pattern_high_ff;
   logic [4:0]       pattern_length_ff;
   logic [4:0]       len_eff;
   logic             req_accept;
   logic             pop;
   word_type         front_word;
   word_type         head_word;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (pattern_length_ff > 5'(PatMax)) ? 5'(PatMax) : pattern_length_ff;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   ffpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .value_char (req_value_char),
      .last_char  (req_last_char),
      .word       (front_word)
   );

   ffpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_word (front_word),
      .pop       (pop),
      .head_word (head_word),
      .status    (q_status)
   );

   ffpc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pattern       ({pattern_high_ff, pattern_low_ff}),
      .len_eff       (len_eff),
      .word          (head_word),
      .word_valid    (!q_status.empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_format_ok (rsp_format_ok),
      .rsp_stall     (rsp_stall)
   );

`ifndef NO_ASSERTIONS
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_status.empty && !req_stall))
      else $error("state not cleared by reset");

   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      (pop && head_word.last) |=> rsp_valid)
      else $error("last word retired without a result");

   a_queue_flags : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("word taken from empty queue");
`endif

endmodule

`default_nettype wire

[verif/verdict_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// scoreboard for field_format_pattern_check: keeps its own copy of the pattern
// registers and match state, predicts the pass/fail word of each value and checks it
// depends on ffpc_pkg
package verdict_scoreboard_pkg;
   import ffpc_pkg::*;

   class verdict_scoreboard;
      logic [63:0] pattern_low_copy;
      logic [63:0] pattern_high_copy;
      logic [4:0]  pattern_length_copy;
      int unsigned position;
      bit          repeating;
      bit          drop_armed;
      bit          char_failed;
      bit          expected_verdicts[$];
      int unsigned mismatches;

      function new();
         pattern_low_copy    = '0;
         pattern_high_copy   = '0;
         pattern_length_copy = '0;
         mismatches          = 0;
         restart_value();
      endfunction

      function void restart_value();
         position    = 0;
         repeating   = 0;
         drop_armed  = 1;
         char_failed = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [63:0] data);
         case (idx)
            CSR_PATTERN_LOW:    pattern_low_copy = data;
            CSR_PATTERN_HIGH:   pattern_high_copy = data;
            CSR_PATTERN_LENGTH: pattern_length_copy = data[4:0];
            default: ;
         endcase
      endfunction

      function int unsigned used_length();
         return (pattern_length_copy > PatMax) ? PatMax : pattern_length_copy;
      endfunction

      // element at a position, -1 past the end
      function int element(int unsigned p);
         if (p >= used_length()) return -1;
         if (p < 8) return int'(pattern_low_copy[8*p +: 8]);
         return int'(pattern_high_copy[8*(p-8) +: 8]);
      endfunction

      function bit fits(int el, logic [7:0] c);
         if (el < 0) return 0;
         case (el[7:0])
            CHAR_DIGIT: return c >= 8'h30 && c <= 8'h39;
            CHAR_ALPHA: return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
            CHAR_PRINT: return c >= 8'h20 && c <= 8'h7E;
            default:    return c == el[7:0];
         endcase
      endfunction

      function void step_forward(int unsigned n);
         position += n;
         if (position > PatMax) position = PatMax;
      endfunction

      function void take_char(logic [7:0] c);
         int el;
         if (repeating) begin
            if (fits(element(position + 1), c)) return;
            repeating = 0;
            step_forward(2);
         end
         el = element(position);
         if (el == CHAR_REPEAT) begin
            if (fits(element(position + 1), c)) repeating = 1;
            else char_failed = 1;
         end else if (fits(el, c)) begin
            step_forward(1);
         end else begin
            char_failed = 1;
         end
      endfunction

      function void note_char(logic [7:0] c, logic last);
         bit verdict;
         if (drop_armed && c == CHAR_ESCAPE) begin
            drop_armed = 0;
         end else begin
            drop_armed = 1;
            if (!char_failed && used_length() != 0) take_char(c);
         end
         if (!last) return;
         if (used_length() == 0) begin
            verdict = 1;
         end else if (char_failed) begin
            verdict = 0;
         end else begin
            if (repeating) step_forward(2);
            if (element(position) == CHAR_REPEAT) step_forward(1);
            verdict = position >= used_length();
         end
         expected_verdicts = {expected_verdicts, verdict};
         restart_value();
      endfunction

      function void check_verdict(logic format_ok);
         bit want;
         if (expected_verdicts.size() == 0) begin
            $error("format_ok: expected none, actual %0b", format_ok);
            mismatches++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (format_ok !== want) begin
            $error("format_ok: expected %0b, actual %0b", want, format_ok);
            mismatches++;
         end
      endfunction

      function int unsigned verdicts_owed();
         return expected_verdicts.size();
      endfunction

      function bit all_clean();
         if (expected_verdicts.size() != 0)
            $error("format_ok: %0d expected words never arrived", expected_verdicts.size());
         return mismatches == 0 && expected_verdicts.size() == 0;
      endfunction
   endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 100ps
// top-level testbench for field_format_pattern_check: streams value words under
// directed and random pattern settings, with random stalls on both channels
// depends on ffpc_pkg, verdict_scoreboard_pkg and the design
module tb_top;
   import ffpc_pkg::*;
   import verdict_scoreboard_pkg::*;

   localparam int StreamItems  = 950;
   localparam int QuietLimit   = 4000;
   localparam int HoldCycles   = 400;
   localparam int SettleCycles = 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_value_char = 8'h00;
   logic          req_last_char = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_format_ok;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_PATTERN_LOW;
   logic [63:0]   csr_data = '0;

   verdict_scoreboard verdicts = new();

   bit           sender_calm = 0;
   bit           receiver_calm = 0;
   bit           hold_request = 0;
   int           items_sent = 0;
   int           quiet_cycles = 0;
   logic [7:0]   value_bytes[$];
   logic [127:0] active_pattern = '0;
   int unsigned  active_length = 0;

   field_format_pattern_check DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_char (req_value_char),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_format_ok  (rsp_format_ok),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side
   initial begin : receiver
      int unsigned hold;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold = HoldCycles;
            hold_request = 0;
         end else begin
            hold = receiver_calm ? 0 : $urandom_range(0, 18);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         verdicts.check_verdict(rsp_format_ok);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      int unsigned gap;
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_char <= c;
      req_last_char  <= last;
      do @(posedge clock); while (req_stall);
      verdicts.note_char(c, last);
      items_sent++;
   endtask

   task automatic send_value();
      foreach (value_bytes[i]) send_char(value_bytes[i], i == value_bytes.size() - 1);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      verdicts.write_register(idx, data);
   endtask

   task automatic set_pattern(input logic [63:0] low, input logic [63:0] high,
                              input logic [4:0] len);
      write_csr(CSR_PATTERN_LOW, low);
      write_csr(CSR_PATTERN_HIGH, high);
      write_csr(CSR_PATTERN_LENGTH, 64'(len));
      csr_valid      <= 1'b0;
      active_pattern = {high, low};
      active_length  = (len > PatMax) ? PatMax : len;
   endtask

   // drain all verdicts before touching the pattern
   task automatic settle();
      req_valid <= 1'b0;
      while (verdicts.verdicts_owed() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [7:0] byte_for(input logic [7:0] el);
      case (el)
         CHAR_DIGIT: return 8'($urandom_range(8'h30, 8'h39));
         CHAR_ALPHA: return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                 : 8'($urandom_range(8'h61, 8'h7A));
         CHAR_PRINT: return 8'($urandom_range(8'h20, 8'h7E));
         default:    return el;
      endcase
   endfunction

   function automatic logic [7:0] random_element();
      case ($urandom_range(0, 9))
         0, 1:    return CHAR_DIGIT;
         2, 3:    return CHAR_ALPHA;
         4:       return CHAR_PRINT;
         5, 6:    return CHAR_REPEAT;
         7:       return CHAR_ESCAPE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_char(input logic [7:0] c);
      if ($urandom_range(0, 9) == 0) value_bytes = {value_bytes, CHAR_ESCAPE};
      value_bytes = {value_bytes, c};
   endfunction

   // mostly values that follow the pattern, some spoilt, some pure noise
   function automatic void make_value();
      int unsigned kind;
      int unsigned p;
      kind = $urandom_range(0, 9);
      value_bytes.delete();
      if (kind < 8) begin
         p = 0;
         while (p < active_length) begin
            if (active_pattern[8*p +: 8] == CHAR_REPEAT) begin
               if (p + 1 < active_length)
                  repeat ($urandom_range(1, 3)) push_char(byte_for(active_pattern[8*(p+1) +: 8]));
               p += 2;
            end else begin
               push_char(byte_for(active_pattern[8*p +: 8]));
               p++;
            end
         end
         if (kind >= 6) begin
            case ($urandom_range(0, 2))
               0: if (value_bytes.size() != 0)
                     value_bytes[$urandom_range(0, value_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
               1: value_bytes = {value_bytes, 8'($urandom_range(0, 255))};
               default: if (value_bytes.size() > 1) void'(value_bytes.pop_back());
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 12)) value_bytes = {value_bytes, 8'($urandom_range(0, 255))};
      end
      if (value_bytes.size() == 0) value_bytes = {value_bytes, CHAR_ESCAPE};
   endfunction

   initial begin : stimulus
      logic [127:0] pattern;
      logic [4:0]   len;
      int           phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty pattern straight out of reset
      value_bytes = '{8'hFF};
      send_value();
      settle();

      // digit, letter, repeated digit, literal, printable, zero literal, trailing repeat
      set_pattern({CHAR_REPEAT, 8'h00, CHAR_PRINT, 8'h2D, CHAR_DIGIT, CHAR_REPEAT,
                   CHAR_ALPHA, CHAR_DIGIT}, '0, 5'd8);
      value_bytes = '{CHAR_ESCAPE, 8'h31, 8'h61, 8'h32, 8'h33, 8'h2D, 8'h7E, 8'h00};
      send_value();
      value_bytes = '{8'h31, 8'h61, 8'h32};
      send_value();
      value_bytes = '{8'h31, CHAR_ESCAPE, CHAR_ESCAPE};
      send_value();
      value_bytes = '{CHAR_ESCAPE};
      send_value();
      value_bytes = '{8'h31, 8'h61, 8'h32, 8'h2D, 8'h7E, 8'h00, 8'h37};
      send_value();
      settle();
      set_pattern('1, '1, 5'd31);
      value_bytes = '{8'hFF, 8'hFF};
      send_value();
      settle();
      set_pattern('0, '0, 5'd16);
      value_bytes = '{8'h00};
      send_value();

      items_sent = 0;
      phase = 0;
      while (items_sent < StreamItems) begin
         settle();
         for (int i = 0; i < 16; i++) pattern[8*i +: 8] = random_element();
         case (phase)
            0:       len = 5'd0;
            1:       len = 5'd31;
            2:       len = 5'd16;
            default: len = 5'($urandom_range(1, 20));
         endcase
         set_pattern(pattern[63:0], pattern[127:64], len);
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // result side held off while words keep coming
            hold_request = 1;
            sender_calm  = 1;
            repeat (30) begin
               value_bytes = '{8'($urandom_range(0, 255))};
               send_value();
            end
            sender_calm = 0;
         end
         repeat ($urandom_range(8, 14)) begin
            make_value();
            send_value();
         end
         phase++;
      end

      settle();
      if (verdicts.all_clean()) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
design/ffpc_pkg.sv
design/ffpc_front.sv
design/ffpc_queue.sv
design/ffpc_back.sv
design/field_format_pattern_check.sv
verif/verdict_scoreboard_pkg.sv
verif/tb_top.sv
